// ----- src/chtl_pkg.sv -----
// shared constants for the channel threshold time latch block
package chtl_pkg;

  // default sizing
  localparam int DEF_CHANNELS  = 512;
  localparam int DEF_TIME_BITS = 32;

  // fixed field widths
  localparam int MODE_W  = 2;
  localparam int CHAN_W  = 9;
  localparam int HTIME_W = 32;
  localparam int COUNT_W = 16;
  localparam int OTIME_W = 32;

  // configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [APB_ADDR_W-1:0] ADDR_TRIGGER_COUNT = 3'd0;
  localparam logic [COUNT_W-1:0]    TRIGGER_COUNT_RST  = 16'd263;

  // transaction modes
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HIT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

endpackage

// ----- src/channel_threshold_time_latch_top.sv -----
// multi-channel photon counter with threshold trigger and latched trigger time
// a read result passes through stage 1, where the memory read is registered, and then the output register
// throughput: one hit or read per cycle while in_stall is low; the state memory has its own read and write port,
//   with a forwarding path for back-to-back hits on one channel
// a clear walks every channel, one entry per cycle, holding in_stall until the last channel is cleared
// reset (synchronous, rst_n low) runs the same clearing pass before items flow
module channel_threshold_time_latch_top #(
  parameter int CHANNELS  = chtl_pkg::DEF_CHANNELS,
  parameter int TIME_BITS = chtl_pkg::DEF_TIME_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [chtl_pkg::MODE_W-1:0]       in_mode,
  input  logic [chtl_pkg::CHAN_W-1:0]       in_channel,
  input  logic [chtl_pkg::HTIME_W-1:0]      in_hit_time,
  input  logic                              in_is_scint_photon,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [chtl_pkg::CHAN_W-1:0]       out_channel,
  output logic                              out_triggered,
  output logic [chtl_pkg::OTIME_W-1:0]      out_trigger_time,
  output logic [chtl_pkg::COUNT_W-1:0]      out_photon_count,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [chtl_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [chtl_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [chtl_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import chtl_pkg::*;

  // memory entry layout: {flag, time, count}
  localparam int AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ENTRY_W = 1 + TIME_BITS + COUNT_W;
  localparam int FLAG_B  = TIME_BITS + COUNT_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(CHANNELS - 1);

  // ---------------------------------------------------------------------------
  // configuration register
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] trig_cnt_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_TRIGGER_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_cnt_r <= TRIGGER_COUNT_RST;
    end else if (cfg_wr) begin
      trig_cnt_r <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_TRIGGER_COUNT) ? APB_DATA_W'(trig_cnt_r) : '0;

  // ---------------------------------------------------------------------------
  // state memory: one entry per channel, one write port and one registered read
  // ---------------------------------------------------------------------------
  logic [ENTRY_W-1:0] mem [CHANNELS];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  // ---------------------------------------------------------------------------
  // clearing pass
  // ---------------------------------------------------------------------------
  logic          sweep_r;
  logic [AW-1:0] sweep_cnt_r;

  // ---------------------------------------------------------------------------
  // stage 1: item waiting on its memory read
  // ---------------------------------------------------------------------------
  logic                 s1_valid_r;
  logic [MODE_W-1:0]    s1_mode_r;
  logic [CHAN_W-1:0]    s1_chan_r;
  logic [AW-1:0]        s1_addr_r;
  logic                 s1_in_range_r;
  logic [TIME_BITS-1:0] s1_time_r;
  logic                 s1_photon_r;
  logic                 fwd_r;
  logic [ENTRY_W-1:0]   fwd_data_r;

  logic                 accept;
  logic                 s1_adv;
  logic                 in_range;
  logic [AW-1:0]        acc_addr;

  // output register
  logic                 out_valid_r;
  logic                 out_load;
  logic [CHAN_W-1:0]    out_chan_r;
  logic                 out_flag_r;
  logic [OTIME_W-1:0]   out_time_r;
  logic [COUNT_W-1:0]   out_count_r;

  // a read in stage 1 only moves on when the output register can take it
  assign s1_adv   = !s1_valid_r || (s1_mode_r != MODE_READ) || !out_valid_r || !out_stall;
  assign in_stall = sweep_r || !s1_adv;
  assign accept   = in_valid && !in_stall;
  assign in_range = (32'(in_channel) < CHANNELS);
  assign acc_addr = AW'(in_channel);

  // current entry for stage 1, with the write of the previous hit forwarded
  logic [ENTRY_W-1:0]   cur;
  logic                 cur_flag;
  logic [COUNT_W-1:0]   cur_count;
  logic [TIME_BITS-1:0] cur_time;
  logic [COUNT_W-1:0]   thr;
  logic [COUNT_W-1:0]   cnt_inc;
  logic                 hit_upd;
  logic [ENTRY_W-1:0]   hit_data;

  assign cur       = fwd_r ? fwd_data_r : rd_data_r;
  assign cur_flag  = cur[FLAG_B];
  assign cur_time  = cur[COUNT_W +: TIME_BITS];
  assign cur_count = cur[COUNT_W-1:0];

  // zero threshold behaves as one
  assign thr     = (trig_cnt_r == '0) ? COUNT_W'(1) : trig_cnt_r;
  assign cnt_inc = cur_count + COUNT_W'(1);

  assign hit_upd = s1_valid_r && (s1_mode_r == MODE_HIT) && s1_photon_r &&
                   s1_in_range_r && !cur_flag;

  always_comb begin
    if (cnt_inc >= thr) begin
      hit_data = {1'b1, s1_time_r, cnt_inc};
    end else begin
      hit_data = {1'b0, cur_time, cnt_inc};
    end
  end

  // the sweep and a hit never write in the same cycle
  assign wr_en   = sweep_r || hit_upd;
  assign wr_addr = sweep_r ? sweep_cnt_r : s1_addr_r;
  assign wr_data = sweep_r ? '0 : hit_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_data_r <= mem[acc_addr];
    end
  end

  // clearing pass control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
    end else if (accept && (in_mode == MODE_CLEAR)) begin
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
    end else if (sweep_r) begin
      if (sweep_cnt_r == LAST_ADDR) begin
        sweep_r <= 1'b0;
      end
      sweep_cnt_r <= sweep_cnt_r + AW'(1);
    end
  end

  // stage 1 control; a clear never enters the stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= (in_mode != MODE_CLEAR);
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // stage 1 payload, plus a hit on the same channel written at this very edge
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode_r     <= in_mode;
      s1_chan_r     <= in_channel;
      s1_addr_r     <= acc_addr;
      s1_in_range_r <= in_range;
      s1_time_r     <= TIME_BITS'(in_hit_time);
      s1_photon_r   <= in_is_scint_photon;
      fwd_r         <= hit_upd && (s1_addr_r == acc_addr);
      fwd_data_r    <= hit_data;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  assign out_load = s1_valid_r && (s1_mode_r == MODE_READ) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // a channel beyond the array reports a zero flag, time and count
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chan_r <= s1_chan_r;
      if (s1_in_range_r) begin
        out_flag_r  <= cur_flag;
        out_time_r  <= OTIME_W'(cur_time);
        out_count_r <= cur_count;
      end else begin
        out_flag_r  <= 1'b0;
        out_time_r  <= '0;
        out_count_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_channel      = out_chan_r;
  assign out_triggered    = out_flag_r;
  assign out_trigger_time = out_time_r;
  assign out_photon_count = out_count_r;

endmodule

// ----- src/chtl_checker.sv -----
// port-level checks for the channel threshold time latch block, bound to the top level
module chtl_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [chtl_pkg::MODE_W-1:0]       in_mode,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [chtl_pkg::CHAN_W-1:0]       out_channel,
  input logic                              out_triggered,
  input logic [chtl_pkg::OTIME_W-1:0]      out_trigger_time,
  input logic [chtl_pkg::COUNT_W-1:0]      out_photon_count,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [chtl_pkg::APB_ADDR_W-1:0]   paddr,
  input logic [chtl_pkg::APB_DATA_W-1:0]   pwdata,
  input logic [chtl_pkg::APB_DATA_W-1:0]   prdata,
  input logic                              pready
);
  import chtl_pkg::*;

  logic in_acc;
  logic cfg_acc;

  assign in_acc  = in_valid && !in_stall;
  assign cfg_acc = psel && penable && pwrite && pready && (paddr == ADDR_TRIGGER_COUNT);

  // reset starts the clearing pass
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // a clear transaction stalls the input while channels are wiped
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_mode == MODE_CLEAR) |=> in_stall)
    else $error("input not stalled after clear");

  // a read finds out_valid high once it has moved through stage 1, with its own result or a stalled earlier one
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_mode == MODE_READ) |-> ##2 out_valid)
    else $error("read result missing");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_channel) && $stable(out_triggered)
      && $stable(out_trigger_time) && $stable(out_photon_count))
    else $error("stalled result changed");

  // the threshold register reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> (paddr != ADDR_TRIGGER_COUNT) ||
      (prdata == APB_DATA_W'($past(pwdata[COUNT_W-1:0]))))
    else $error("threshold readback mismatch");

endmodule

bind channel_threshold_time_latch_top chtl_checker u_chtl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_mode          (in_mode),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_channel      (out_channel),
  .out_triggered    (out_triggered),
  .out_trigger_time (out_trigger_time),
  .out_photon_count (out_photon_count),
  .psel             (psel),
  .penable          (penable),
  .pwrite           (pwrite),
  .paddr            (paddr),
  .pwdata           (pwdata),
  .prdata           (prdata),
  .pready           (pready)
);

// ----- dv/chtl_tally_checker.sv -----
// checker for the channel threshold time latch: tracks per-channel tallies and checks readouts
module chtl_tally_checker #(
  parameter int CHANNELS  = chtl_pkg::DEF_CHANNELS,
  parameter int TIME_BITS = chtl_pkg::DEF_TIME_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [chtl_pkg::MODE_W-1:0]     in_mode,
  input  logic [chtl_pkg::CHAN_W-1:0]     in_channel,
  input  logic [chtl_pkg::HTIME_W-1:0]    in_hit_time,
  input  logic                            in_is_scint_photon,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [chtl_pkg::CHAN_W-1:0]     out_channel,
  input  logic                            out_triggered,
  input  logic [chtl_pkg::OTIME_W-1:0]    out_trigger_time,
  input  logic [chtl_pkg::COUNT_W-1:0]    out_photon_count,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [chtl_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [chtl_pkg::APB_DATA_W-1:0] pwdata,
  input  logic [chtl_pkg::APB_DATA_W-1:0] prdata,
  input  logic                            pready,
  output int                              mismatches,
  output int                              outstanding,
  output int                              latched_count,
  output int                              checked_count
);
  import chtl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic               trig;
    logic [OTIME_W-1:0] tm;
    logic [COUNT_W-1:0] cnt;
  } readout_t;

  logic [COUNT_W-1:0] photons [CHANNELS];
  logic               flags   [CHANNELS];
  logic [63:0]        latched [CHANNELS];
  logic [COUNT_W-1:0] threshold;
  readout_t           pending_readouts [$];

  function automatic logic [63:0] time_mask();
    return (TIME_BITS >= 64) ? '1 : ((64'd1 << TIME_BITS) - 64'd1);
  endfunction

  task automatic clear_channels();
    for (int i = 0; i < CHANNELS; i++) begin
      photons[i] = '0;
      flags[i]   = 1'b0;
      latched[i] = '0;
    end
  endtask

  // one accepted transaction against the channel tallies
  task automatic apply_transaction(input logic [MODE_W-1:0] mode, input logic [CHAN_W-1:0] ch,
                                   input logic [HTIME_W-1:0] t, input logic photon);
    logic [COUNT_W-1:0] level;
    readout_t           ro;
    level = (threshold == '0) ? COUNT_W'(1) : threshold;
    case (mode)
      MODE_CLEAR: begin
        clear_channels();
      end
      MODE_HIT: begin
        if (photon && ch < CHANNELS && !flags[ch]) begin
          photons[ch] = photons[ch] + COUNT_W'(1);
          if (photons[ch] >= level) begin
            flags[ch]   = 1'b1;
            latched[ch] = {32'd0, t} & time_mask();
            latched_count++;
          end
        end
      end
      MODE_READ: begin
        ro.chan = ch;
        if (ch < CHANNELS) begin
          ro.trig = flags[ch];
          ro.tm   = latched[ch][OTIME_W-1:0];
          ro.cnt  = photons[ch];
        end else begin
          ro.trig = 1'b0;
          ro.tm   = '0;
          ro.cnt  = '0;
        end
        pending_readouts.push_back(ro);
      end
      default: ;
    endcase
  endtask

  initial begin
    mismatches    = 0;
    outstanding   = 0;
    latched_count = 0;
    checked_count = 0;
  end

  always @(posedge clk) begin
    readout_t want;
    if (!rst_n) begin
      clear_channels();
      threshold = TRIGGER_COUNT_RST;
      pending_readouts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_readouts.size() == 0) begin
          $error("readout of channel %0d with no read pending", out_channel);
          mismatches++;
        end else begin
          want = pending_readouts.pop_front();
          checked_count++;
          if (out_channel !== want.chan) begin
            $error("out_channel: expected %0d, got %0d", want.chan, out_channel);
            mismatches++;
          end
          if (out_triggered !== want.trig) begin
            $error("out_triggered: expected %0d, got %0d", want.trig, out_triggered);
            mismatches++;
          end
          if (out_trigger_time !== want.tm) begin
            $error("out_trigger_time: expected %0h, got %0h", want.tm, out_trigger_time);
            mismatches++;
          end
          if (out_photon_count !== want.cnt) begin
            $error("out_photon_count: expected %0d, got %0d", want.cnt, out_photon_count);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall)
        apply_transaction(in_mode, in_channel, in_hit_time, in_is_scint_photon);
      if (psel && penable && pready && paddr == ADDR_TRIGGER_COUNT) begin
        if (pwrite) begin
          threshold = pwdata[COUNT_W-1:0];
        end else if (prdata[COUNT_W-1:0] !== threshold) begin
          $error("trigger_count readback: expected %0d, got %0d", threshold,
                 prdata[COUNT_W-1:0]);
          mismatches++;
        end
      end
    end
    outstanding <= pending_readouts.size();
  end

endmodule

// ----- dv/channel_threshold_time_latch_top_test.sv -----
// testbench top for the channel threshold time latch: stimulus, reset, clock and verdict
module channel_threshold_time_latch_top_test;
  import chtl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // mode code the block leaves unused
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int NUM_PHASES = 6;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [MODE_W-1:0]     in_mode;
  logic [CHAN_W-1:0]     in_channel;
  logic [HTIME_W-1:0]    in_hit_time;
  logic                  in_is_scint_photon;
  logic                  out_valid;
  logic                  out_stall;
  logic [CHAN_W-1:0]     out_channel;
  logic                  out_triggered;
  logic [OTIME_W-1:0]    out_trigger_time;
  logic [COUNT_W-1:0]    out_photon_count;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatches;
  int outstanding;
  int latched_count;
  int checked_count;

  // transaction tallies for the closing summary
  int hits_sent;
  int reads_sent;
  int clears_sent;
  int ignored_sent;
  int settings_used;

  channel_threshold_time_latch_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_channel         (in_channel),
    .in_hit_time        (in_hit_time),
    .in_is_scint_photon (in_is_scint_photon),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_channel        (out_channel),
    .out_triggered      (out_triggered),
    .out_trigger_time   (out_trigger_time),
    .out_photon_count   (out_photon_count),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // the checker sits beside the block and watches every channel
  chtl_tally_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_channel         (in_channel),
    .in_hit_time        (in_hit_time),
    .in_is_scint_photon (in_is_scint_photon),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_channel        (out_channel),
    .out_triggered      (out_triggered),
    .out_trigger_time   (out_trigger_time),
    .out_photon_count   (out_photon_count),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .mismatches         (mismatches),
    .outstanding        (outstanding),
    .latched_count      (latched_count),
    .checked_count      (checked_count)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure: alternating release and stall spans,
  // some release spans long enough to let results stream freely
  initial begin
    int span;
    out_stall = 1'b0;
    forever begin
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : idle_span() + 1;
      repeat (span) @(negedge clk) out_stall <= 1'b0;
      span = idle_span();
      repeat (span) @(negedge clk) out_stall <= 1'b1;
    end
  end

  // one transaction on the input channel, preceded by gap idle cycles;
  // the payload wanders while valid is low so a block that ignores valid shows up
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [CHAN_W-1:0] ch,
                           input logic [HTIME_W-1:0] t, input logic photon, input int gap);
    repeat (gap) @(negedge clk) begin
      in_valid           <= 1'b0;
      in_mode            <= MODE_W'($urandom);
      in_channel         <= CHAN_W'($urandom);
      in_hit_time        <= $urandom;
      in_is_scint_photon <= 1'($urandom);
    end
    @(negedge clk);
    in_valid           <= 1'b1;
    in_mode            <= mode;
    in_channel         <= ch;
    in_hit_time        <= t;
    in_is_scint_photon <= photon;
    do @(posedge clk); while (in_stall);
    case (mode)
      MODE_CLEAR: clears_sent++;
      MODE_HIT:   hits_sent++;
      MODE_READ:  reads_sent++;
      default:    ignored_sent++;
    endcase
  endtask

  // drop valid, wait for every readout, then let a trailing hit or clear finish
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    while (in_stall) @(negedge clk);
  endtask

  // setup cycle then access cycle on the register port
  task automatic cfg_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // new threshold with the block idle, upper data bits random, then read back
  task automatic set_threshold(input logic [COUNT_W-1:0] level);
    settle();
    cfg_access(1'b1, ADDR_TRIGGER_COUNT, {16'($urandom), level});
    cfg_access(1'b0, ADDR_TRIGGER_COUNT, '0);
    settings_used++;
  endtask

  function automatic logic [HTIME_W-1:0] pick_time();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // events: a clear, a stream of hits and reads mostly aimed at a small pool
  // of channels, then a read sweep of that pool; a few events skip the clear
  // so tallies carry over, and some items are noise
  task automatic run_events(input int n_items, input int pool_n, input bit one_long);
    logic [CHAN_W-1:0] pool [8];
    logic [CHAN_W-1:0] ch;
    int                sent;
    int                ev_len;
    int                r;
    int                hit_cut;
    bit                burst;
    sent    = 0;
    hit_cut = one_long ? 92 : 78;
    while (sent < n_items) begin
      for (int k = 0; k < pool_n; k++) begin
        r = $urandom_range(0, 9);
        pool[k] = (r == 0) ? CHAN_W'(0) : (r == 1) ? CHAN_W'(DEF_CHANNELS - 1)
                                                   : CHAN_W'($urandom_range(0, 511));
      end
      // some events run back to back with no idling at all
      burst  = ($urandom_range(0, 4) == 0);
      ev_len = one_long ? n_items - sent : $urandom_range(15, 60);
      if ($urandom_range(0, 9) != 0)
        send_item(MODE_CLEAR, CHAN_W'($urandom), $urandom, 1'($urandom),
                  burst ? 0 : idle_span());
      for (int k = 0; k < ev_len; k++) begin
        r  = $urandom_range(0, 99);
        ch = ($urandom_range(0, 9) == 0) ? CHAN_W'($urandom)
                                         : pool[$urandom_range(0, pool_n - 1)];
        if (r < 3)
          send_item(MODE_UNUSED, ch, pick_time(), 1'($urandom), burst ? 0 : idle_span());
        else if (r < hit_cut)
          send_item(MODE_HIT, ch, pick_time(), 1'($urandom_range(0, 19) != 0),
                    burst ? 0 : idle_span());
        else
          send_item(MODE_READ, ch, pick_time(), 1'($urandom), burst ? 0 : idle_span());
      end
      for (int k = 0; k < pool_n; k++)
        send_item(MODE_READ, pool[k], $urandom, 1'($urandom), burst ? 0 : idle_span());
      sent += ev_len + pool_n + 1;
    end
  endtask

  initial begin
    logic [COUNT_W-1:0] phase_levels [NUM_PHASES];
    logic [COUNT_W-1:0] level;
    hits_sent          = 0;
    reads_sent         = 0;
    clears_sent        = 0;
    ignored_sent       = 0;
    settings_used      = 0;
    in_valid           = 1'b0;
    in_mode            = MODE_CLEAR;
    in_channel         = '0;
    in_hit_time        = '0;
    in_is_scint_photon = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    rst_n              = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: reset threshold, channel extremes, ignored hits, unused mode
    send_item(MODE_READ, CHAN_W'(0), '0, 1'b0, 0);
    send_item(MODE_READ, CHAN_W'(511), '1, 1'b1, 0);
    send_item(MODE_HIT, CHAN_W'(511), '1, 1'b1, 0);
    send_item(MODE_HIT, CHAN_W'(511), 32'h1234_5678, 1'b0, 1);
    send_item(MODE_HIT, CHAN_W'(3), '0, 1'b1, 0);
    send_item(MODE_UNUSED, CHAN_W'(3), '1, 1'b1, 0);
    send_item(MODE_READ, CHAN_W'(511), '0, 1'b0, 0);
    send_item(MODE_READ, CHAN_W'(3), '0, 1'b0, 2);
    send_item(MODE_CLEAR, CHAN_W'(3), '0, 1'b0, 0);
    send_item(MODE_READ, CHAN_W'(511), '0, 1'b0, 0);

    // zero threshold behaves as one: first photon triggers, later ones are frozen out
    set_threshold('0);
    send_item(MODE_HIT, CHAN_W'(0), '1, 1'b1, 0);
    send_item(MODE_HIT, CHAN_W'(0), 32'd5, 1'b1, 0);
    send_item(MODE_HIT, CHAN_W'(511), 32'd7, 1'b0, 0);
    send_item(MODE_READ, CHAN_W'(0), '0, 1'b0, 0);
    send_item(MODE_READ, CHAN_W'(511), '0, 1'b0, 0);

    // largest threshold: counts grow without triggering
    set_threshold('1);
    repeat (3) send_item(MODE_HIT, CHAN_W'(2), $urandom, 1'b1, 0);
    send_item(MODE_READ, CHAN_W'(2), '0, 1'b0, 0);

    // lowered threshold: a channel already past it triggers on its next photon
    set_threshold(COUNT_W'(2));
    send_item(MODE_HIT, CHAN_W'(9), 32'hAAAA_AAAA, 1'b1, 0);
    send_item(MODE_HIT, CHAN_W'(9), 32'h5555_5555, 1'b1, 0);
    send_item(MODE_HIT, CHAN_W'(9), 32'hFFFF_0000, 1'b1, 0);
    send_item(MODE_READ, CHAN_W'(9), '0, 1'b0, 0);
    send_item(MODE_READ, CHAN_W'(2), '0, 1'b0, 0);
    send_item(MODE_HIT, CHAN_W'(2), 32'h0000_FFFF, 1'b1, 0);
    send_item(MODE_READ, CHAN_W'(2), '0, 1'b0, 0);

    // random phases, one threshold each; the reset value gets a long single
    // event aimed at one channel so it actually reaches the trigger
    phase_levels = '{COUNT_W'(5), COUNT_W'(1), TRIGGER_COUNT_RST, '1,
                     COUNT_W'($urandom_range(3, 40)), COUNT_W'(2)};
    for (int p = 0; p < NUM_PHASES; p++) begin
      level = phase_levels[p];
      set_threshold(level);
      if (level == TRIGGER_COUNT_RST)
        run_events(420, 1, 1'b1);
      else
        run_events(60, $urandom_range(1, 6), 1'b0);
    end

    // drain: every readout back, then a wait for stray results
    @(negedge clk) in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d hits, %0d reads, %0d clears, %0d unused-mode transactions",
             hits_sent, reads_sent, clears_sent, ignored_sent);
    $display("over %0d threshold settings: %0d triggers latched, %0d readouts checked",
             settings_used, latched_count, checked_count);
    if (mismatches == 0) begin
      $display("PASS channel_threshold_time_latch_top");
    end else begin
      $display("FAIL channel_threshold_time_latch_top");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("FAIL channel_threshold_time_latch_top");
    $finish;
  end

endmodule

// ----- files.f -----
src/chtl_pkg.sv
src/channel_threshold_time_latch_top.sv
src/chtl_checker.sv
dv/chtl_tally_checker.sv
dv/channel_threshold_time_latch_top_test.sv
